### hdl/sha_pkg.sv
package sha_pkg;

    // Round constants of the compression function.
    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Initial chaining value.
    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic       KIND_BYTE   = 1'b0;
    localparam logic       KIND_FINISH = 1'b1;
    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam int         QUEUE_DEPTH = 4;

    // Request passed from the front end to the round engine.
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_req;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_PAD,
        ST_ROUNDS,
        ST_ADD,
        ST_EMIT
    } t_eng_state;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

### hdl/sha_front.sv
module sha_front
    import sha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic       i_kind,
    input  logic [7:0] i_data_byte,
    output logic       o_req_valid,
    output t_req       o_req,
    input  logic       i_req_take
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_req            r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;
    logic            w_push, w_pop;

    assign o_full      = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_mem[r_rp];
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_req_take && o_req_valid;

    // Queue storage; the data byte is cleared on a finish request.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp].kind      <= i_kind;
            r_mem[r_wp].data_byte <= (i_kind == KIND_FINISH) ? 8'h00 : i_data_byte;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
    end

endmodule

### hdl/sha_engine.sv
module sha_engine
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  t_req        i_req,
    output logic        o_req_take,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_eng_state  r_state, n_state;
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [5:0]  r_round;
    logic [60:0] r_nblk;
    logic [5:0]  r_fill;
    logic [63:0] r_total;
    logic        r_final;
    logic        r_padding;
    logic        r_pad_first;
    logic [2:0]  r_oi;

    logic [31:0] w_cur, w_new, t1, t2, s0, s1;
    logic [31:0] w_word;
    logic [7:0]  w_pad_byte;
    logic        w_byte_take;

    // Message schedule: word 0 is the current round's input.
    always_comb begin
        s0    = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        w_cur = r_w[0];
        t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + K_ROUND[r_round] + w_cur;
        t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // Padding byte for the current fill position: the marker byte first, then zeros,
    // and the big-endian bit length in the last eight bytes of the final block.
    always_comb begin
        w_pad_byte = 8'h00;
        if (r_pad_first) w_pad_byte = PAD_BYTE;
        else if (r_final && r_fill >= 6'd56)
            w_pad_byte = r_total[{~r_fill[2:0], 3'b000} +: 8];
    end

    // Control.
    always_comb begin
        n_state     = r_state;
        o_req_take  = 1'b0;
        w_byte_take = 1'b0;
        case (r_state)
            ST_COLLECT: begin
                if (i_req_valid) begin
                    o_req_take = 1'b1;
                    if (i_req.kind == KIND_BYTE) begin
                        w_byte_take = 1'b1;
                        if (r_fill == 6'd63) n_state = ST_ROUNDS;
                    end else begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: if (r_fill == 6'd63) n_state = ST_ROUNDS;
            ST_ROUNDS: if (r_round == 6'd63) n_state = ST_ADD;
            ST_ADD: begin
                if (r_final) n_state = ST_EMIT;
                else if (r_padding) n_state = ST_PAD;
                else n_state = ST_COLLECT;
            end
            ST_EMIT: if (i_pop && r_oi == 3'd7) n_state = ST_COLLECT;
            default: n_state = ST_COLLECT;
        endcase
    end

    assign w_word = {r_w[15][23:0], (r_state == ST_PAD) ? w_pad_byte : i_req.data_byte};

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_fill      <= '0;
            r_round     <= '0;
            r_nblk      <= '0;
            r_final     <= 1'b0;
            r_padding   <= 1'b0;
            r_pad_first <= 1'b0;
            r_oi        <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= H_INIT[i];
        end else begin
            r_state <= n_state;
            if (w_byte_take || r_state == ST_PAD) begin
                // The first byte of each word shifts the window; later bytes fill it.
                if (r_fill[1:0] == 2'd0) begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_word;
                end else begin
                    r_w[15] <= w_word;
                end
                r_fill <= r_fill + 6'd1;
                if (r_state == ST_PAD) r_pad_first <= 1'b0;
            end
            if (r_state == ST_COLLECT && i_req_valid && i_req.kind == KIND_FINISH) begin
                r_total     <= {r_nblk, 3'b000} + {55'd0, r_fill, 3'b000};
                r_padding   <= 1'b1;
                r_pad_first <= 1'b1;
                r_final     <= (r_fill < 6'd56);
            end
            if (n_state == ST_ROUNDS && r_state != ST_ROUNDS) begin
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                r_round <= '0;
            end
            if (r_state == ST_ROUNDS) begin
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= w_new;
                r_round <= r_round + 6'd1;
            end
            if (r_state == ST_ADD) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                if (!r_padding) r_nblk <= r_nblk + 61'd64;
                // The block after an overflowing pad carries the length.
                if (r_padding && !r_final) r_final <= 1'b1;
            end
            if (r_state == ST_EMIT && i_pop) begin
                r_oi <= r_oi + 3'd1;
                if (r_oi == 3'd7) begin
                    for (int i = 0; i < 8; i++) r_h[i] <= H_INIT[i];
                    r_nblk    <= '0;
                    r_fill    <= '0;
                    r_final   <= 1'b0;
                    r_padding <= 1'b0;
                end
            end
        end
    end

    assign o_empty       = (r_state != ST_EMIT);
    assign o_digest_word = r_h[r_oi];
    assign o_word_index  = r_oi;
    assign o_last_word   = (r_oi == 3'd7);

endmodule

### hdl/sha256_stream_hasher.sv
// Channel   | Handshake         | Payload
// input     | i_push / o_full   | i_kind, i_data_byte
// result    | o_empty / i_pop   | o_digest_word, o_word_index, o_last_word
// Bytes are taken one at a time while collecting; each full 64-byte block then
// passes through the single round unit (64 rounds plus chain update), during
// which bytes wait in the front queue. A finish pads the block, compresses once
// or twice and then holds eight results until they are popped.
// Reset is synchronous and active low; it restores the initial chaining value.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_kind,
    input  logic [7:0]  i_data_byte,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    logic w_valid, w_take;
    t_req w_req;

    sha_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_kind, .i_data_byte,
        .o_req_valid(w_valid), .o_req(w_req), .i_req_take(w_take)
    );

    sha_engine u_engine (
        .i_clk, .i_rst_n, .i_req_valid(w_valid), .i_req(w_req), .o_req_take(w_take),
        .o_empty, .i_pop, .o_digest_word, .o_word_index, .o_last_word
    );

endmodule

### hdl/sha_checker.sv
module sha_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_empty,
    input logic       i_pop,
    input logic [2:0] o_word_index,
    input logic       o_last_word
);

    // The last flag marks exactly the eighth word.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_last_word == (o_word_index == 3'd7)))
        else $error("last flag mismatch");

    // Popping a word that is not last advances the index.
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && !o_last_word) |=> (!o_empty &&
            o_word_index == $past(o_word_index) + 3'd1))
        else $error("word index did not advance");

    // After the last word the result side goes empty.
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && o_last_word) |=> o_empty)
        else $error("results continue after last word");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
    .i_clk, .i_rst_n, .o_empty, .i_pop, .o_word_index, .o_last_word
);
